// File: src/uehash_pkg.sv
// uehash_pkg: shared constants, types and codes for the edge hash table
// no dependencies; used by every other file of the block except uehash_ram

package uehash_pkg;

    // field widths
    localparam int VERTEX_BITS  = 10;
    localparam int WEIGHT_BITS  = 16;
    localparam int STATUS_BITS  = 3;

    // table geometry (bucket count is at least the hash modulus, so hash is the bucket)
    localparam int BUCKET_COUNT = 97;
    localparam int WAYS         = 4;
    localparam int SLOT_COUNT   = BUCKET_COUNT * WAYS;
    localparam int ADDR_BITS    = $clog2(SLOT_COUNT);
    localparam int WAY_BITS     = (WAYS > 1) ? $clog2(WAYS) : 1;

    // hash constants
    localparam int HASH_MULT    = 33;
    localparam int HASH_MOD     = 97;
    localparam int BUCKET_BITS  = $clog2(HASH_MOD);
    localparam int SUM_BITS     = VERTEX_BITS + 1;
    localparam int HPROD_BITS   = SUM_BITS + $clog2(HASH_MULT);

    // reciprocal for mod by HASH_MOD: quotient estimate is low by at most one
    localparam int RECIP_SHIFT  = HPROD_BITS + BUCKET_BITS;
    localparam int RECIP_BITS   = RECIP_SHIFT - BUCKET_BITS + 1;
    localparam int Q_BITS       = HPROD_BITS - BUCKET_BITS + 1;
    localparam logic [RECIP_BITS-1:0] RECIP_MULT =
        RECIP_BITS'((64'd1 << RECIP_SHIFT) / HASH_MOD);

    // shared multiplier widths
    localparam int MUL_A_BITS   = HPROD_BITS;
    localparam int MUL_B_BITS   = RECIP_BITS;
    localparam int MUL_P_BITS   = MUL_A_BITS + MUL_B_BITS;

    // operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // result codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FOUND    = 3'd2,
        ST_MISSING  = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    // one slot of the table
    typedef struct packed {
        logic                   valid;
        logic [VERTEX_BITS-1:0] va;
        logic [VERTEX_BITS-1:0] vb;
        logic [WEIGHT_BITS-1:0] weight;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    // sequencer states
    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_MUL33,
        S_RECIP,
        S_BACK,
        S_FIX,
        S_BASE,
        S_RD,
        S_CMP,
        S_WR,
        S_OUT
    } t_state;

    // multiplier operand selection
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_HASH,
        MUL_RECIP,
        MUL_BACK,
        MUL_BASE
    } t_mul_sel;

    // sequencer to datapath
    typedef struct packed {
        logic     clr_wr;
        logic     in_ready;
        logic     out_valid;
        t_mul_sel mul_sel;
        logic     save_p;
        logic     set_bucket;
        logic     set_base;
        logic     rd_en;
        logic     cmp_en;
        logic     wr_en;
    } t_seq_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic clr_last;
        logic in_valid;
        logic out_ready;
        logic stop;
    } t_seq_stat;

endpackage

// File: src/uehash_if.sv
// uehash_in_if / uehash_out_if: valid/ready channels of the edge hash table
// depends on uehash_pkg for field widths

interface uehash_in_if;
    logic                               valid;
    logic                               ready;
    logic                               opcode;
    logic [uehash_pkg::VERTEX_BITS-1:0] vertex_a;
    logic [uehash_pkg::VERTEX_BITS-1:0] vertex_b;
    logic [uehash_pkg::WEIGHT_BITS-1:0] edge_weight;

    modport source (output valid, opcode, vertex_a, vertex_b, edge_weight, input ready);
    modport sink   (input valid, opcode, vertex_a, vertex_b, edge_weight, output ready);
endinterface

interface uehash_out_if;
    logic                               valid;
    logic                               ready;
    logic [uehash_pkg::STATUS_BITS-1:0] status;
    logic [uehash_pkg::WEIGHT_BITS-1:0] found_weight;

    modport source (output valid, status, found_weight, input ready);
    modport sink   (input valid, status, found_weight, output ready);
endinterface

// File: src/uehash_mul.sv
// uehash_mul: shared multiplier with registered product
// depends on uehash_pkg for operand widths

module uehash_mul (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [uehash_pkg::MUL_A_BITS-1:0] i_a,
    input  logic [uehash_pkg::MUL_B_BITS-1:0] i_b,
    output logic [uehash_pkg::MUL_P_BITS-1:0] o_prod
);

    logic [uehash_pkg::MUL_P_BITS-1:0] r_prod;

    // product register, held while unused
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= uehash_pkg::MUL_P_BITS'(i_a) * uehash_pkg::MUL_P_BITS'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

// File: src/uehash_ram.sv
// uehash_ram: single write port, single read port memory with registered read
// no dependencies

module uehash_ram #(
    parameter int DEPTH = 388,
    parameter int WIDTH = 37
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/uehash_seq.sv
// uehash_seq: sequencer for clear pass, hash steps, way scan and write-back
// depends on uehash_pkg for state, control and status types

module uehash_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  uehash_pkg::t_seq_stat i_stat,
    output uehash_pkg::t_seq_ctrl o_ctrl
);

    uehash_pkg::t_state r_state;
    uehash_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uehash_pkg::S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            uehash_pkg::S_CLR:   if (i_stat.clr_last) n_state = uehash_pkg::S_IDLE;
            uehash_pkg::S_IDLE:  if (i_stat.in_valid) n_state = uehash_pkg::S_MUL33;
            uehash_pkg::S_MUL33: n_state = uehash_pkg::S_RECIP;
            uehash_pkg::S_RECIP: n_state = uehash_pkg::S_BACK;
            uehash_pkg::S_BACK:  n_state = uehash_pkg::S_FIX;
            uehash_pkg::S_FIX:   n_state = uehash_pkg::S_BASE;
            uehash_pkg::S_BASE:  n_state = uehash_pkg::S_RD;
            uehash_pkg::S_RD:    n_state = uehash_pkg::S_CMP;
            uehash_pkg::S_CMP: begin
                n_state = i_stat.stop ? uehash_pkg::S_WR : uehash_pkg::S_RD;
            end
            uehash_pkg::S_WR:    n_state = uehash_pkg::S_OUT;
            uehash_pkg::S_OUT:   if (i_stat.out_ready) n_state = uehash_pkg::S_IDLE;
            default:             n_state = uehash_pkg::S_CLR;
        endcase
    end

    // control outputs
    always_comb begin
        o_ctrl = '0;
        o_ctrl.mul_sel = uehash_pkg::MUL_NONE;
        case (r_state)
            uehash_pkg::S_CLR:   o_ctrl.clr_wr = 1'b1;
            uehash_pkg::S_IDLE:  o_ctrl.in_ready = 1'b1;
            uehash_pkg::S_MUL33: o_ctrl.mul_sel = uehash_pkg::MUL_HASH;
            uehash_pkg::S_RECIP: begin
                o_ctrl.mul_sel = uehash_pkg::MUL_RECIP;
                o_ctrl.save_p  = 1'b1;
            end
            uehash_pkg::S_BACK:  o_ctrl.mul_sel = uehash_pkg::MUL_BACK;
            uehash_pkg::S_FIX:   o_ctrl.set_bucket = 1'b1;
            uehash_pkg::S_BASE: begin
                o_ctrl.mul_sel  = uehash_pkg::MUL_BASE;
                o_ctrl.set_base = 1'b1;
            end
            uehash_pkg::S_RD:    o_ctrl.rd_en = 1'b1;
            uehash_pkg::S_CMP:   o_ctrl.cmp_en = 1'b1;
            uehash_pkg::S_WR:    o_ctrl.wr_en = 1'b1;
            uehash_pkg::S_OUT:   o_ctrl.out_valid = 1'b1;
            default:             o_ctrl = '0;
        endcase
    end

endmodule

// File: src/undirected_edge_hash_table.sv
// undirected_edge_hash_table: set-associative store of weighted undirected edges
// sequence: five hash steps, then a read step and a compare step for each way scanned,
//   then a write-back step before the result word is offered
// throughput: one word at a time, next word taken the cycle after the result leaves
// reset: a clearing pass over all SLOT_COUNT slots invalidates every slot before any input
// depends on uehash_pkg, uehash_if, uehash_mul, uehash_ram, uehash_seq

module undirected_edge_hash_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    uehash_in_if.sink    i_in,
    uehash_out_if.source o_out
);

    uehash_pkg::t_seq_ctrl w_ctrl;
    uehash_pkg::t_seq_stat w_stat;

    // captured request
    logic                               r_op;
    logic [uehash_pkg::VERTEX_BITS-1:0] r_va;
    logic [uehash_pkg::VERTEX_BITS-1:0] r_vb;
    logic [uehash_pkg::WEIGHT_BITS-1:0] r_wt;
    logic [uehash_pkg::SUM_BITS-1:0]    r_sum;

    // hash and scan state
    logic [uehash_pkg::HPROD_BITS-1:0]  r_p;
    logic [uehash_pkg::BUCKET_BITS-1:0] r_bucket;
    logic [uehash_pkg::WAY_BITS-1:0]    r_way;
    logic                               r_hit;
    logic [uehash_pkg::WAY_BITS-1:0]    r_hit_way;
    logic [uehash_pkg::VERTEX_BITS-1:0] r_hit_va;
    logic [uehash_pkg::VERTEX_BITS-1:0] r_hit_vb;
    logic [uehash_pkg::WEIGHT_BITS-1:0] r_old_wt;
    logic                               r_free;
    logic [uehash_pkg::WAY_BITS-1:0]    r_free_way;
    logic [uehash_pkg::ADDR_BITS-1:0]   r_clr;

    // result
    uehash_pkg::t_status                r_status;
    logic [uehash_pkg::WEIGHT_BITS-1:0] r_fw;

    // multiplier and memory signals
    logic [uehash_pkg::MUL_A_BITS-1:0]  w_mul_a;
    logic [uehash_pkg::MUL_B_BITS-1:0]  w_mul_b;
    logic [uehash_pkg::MUL_P_BITS-1:0]  w_prod;
    logic [uehash_pkg::ADDR_BITS-1:0]   w_base;
    logic [uehash_pkg::HPROD_BITS-1:0]  w_rem;
    logic [uehash_pkg::HPROD_BITS-1:0]  w_rem_fix;
    logic                               w_we;
    logic [uehash_pkg::ADDR_BITS-1:0]   w_waddr;
    uehash_pkg::t_entry                 w_wdata;
    uehash_pkg::t_entry                 w_rdata;
    logic                               w_match;
    logic                               w_last_way;
    logic                               w_in_acc;
    uehash_pkg::t_status                n_status;
    logic [uehash_pkg::WEIGHT_BITS-1:0] n_fw;

    assign w_in_acc = i_in.valid && w_ctrl.in_ready;

    // sequencer
    assign w_stat.clr_last  = (r_clr == uehash_pkg::ADDR_BITS'(uehash_pkg::SLOT_COUNT - 1));
    assign w_stat.in_valid  = i_in.valid;
    assign w_stat.out_ready = o_out.ready;
    assign w_stat.stop      = w_match || w_last_way;

    uehash_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    // multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (w_ctrl.mul_sel)
            uehash_pkg::MUL_HASH: begin
                w_mul_a = uehash_pkg::MUL_A_BITS'(r_sum);
                w_mul_b = uehash_pkg::MUL_B_BITS'(uehash_pkg::HASH_MULT);
            end
            uehash_pkg::MUL_RECIP: begin
                w_mul_a = w_prod[uehash_pkg::HPROD_BITS-1:0];
                w_mul_b = uehash_pkg::RECIP_MULT;
            end
            uehash_pkg::MUL_BACK: begin
                w_mul_a = uehash_pkg::MUL_A_BITS'(w_prod[uehash_pkg::RECIP_SHIFT +: uehash_pkg::Q_BITS]);
                w_mul_b = uehash_pkg::MUL_B_BITS'(uehash_pkg::HASH_MOD);
            end
            uehash_pkg::MUL_BASE: begin
                w_mul_a = uehash_pkg::MUL_A_BITS'(r_bucket);
                w_mul_b = uehash_pkg::MUL_B_BITS'(uehash_pkg::WAYS);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    uehash_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_ctrl.mul_sel != uehash_pkg::MUL_NONE),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // remainder with one correction step, estimate is low by at most one
    assign w_rem     = r_p - w_prod[uehash_pkg::HPROD_BITS-1:0];
    assign w_rem_fix = (w_rem >= uehash_pkg::HPROD_BITS'(uehash_pkg::HASH_MOD))
                     ? w_rem - uehash_pkg::HPROD_BITS'(uehash_pkg::HASH_MOD) : w_rem;

    // bucket base address stays in the product register during the scan
    assign w_base = w_prod[uehash_pkg::ADDR_BITS-1:0];

    // request capture and hash registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op  <= i_in.opcode;
            r_va  <= i_in.vertex_a;
            r_vb  <= i_in.vertex_b;
            r_wt  <= i_in.edge_weight;
            r_sum <= uehash_pkg::SUM_BITS'(i_in.vertex_a) + uehash_pkg::SUM_BITS'(i_in.vertex_b);
        end
        if (w_ctrl.save_p) begin
            r_p <= w_prod[uehash_pkg::HPROD_BITS-1:0];
        end
        if (w_ctrl.set_bucket) begin
            r_bucket <= w_rem_fix[uehash_pkg::BUCKET_BITS-1:0];
        end
    end

    // way compare on the registered read word
    assign w_match = w_ctrl.cmp_en && w_rdata.valid
                  && (((w_rdata.va == r_va) && (w_rdata.vb == r_vb))
                   || ((w_rdata.va == r_vb) && (w_rdata.vb == r_va)));
    assign w_last_way = (r_way == uehash_pkg::WAY_BITS'(uehash_pkg::WAYS - 1));

    // scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_way  <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (w_ctrl.set_base) begin
            r_way  <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (w_ctrl.cmp_en) begin
            if (w_match) begin
                r_hit <= 1'b1;
            end
            if (!w_rdata.valid && !r_free) begin
                r_free <= 1'b1;
            end
            if (!w_stat.stop) begin
                r_way <= r_way + 1'b1;
            end
        end
    end

    // matching and free slot details
    always_ff @(posedge i_clk) begin
        if (w_match) begin
            r_hit_way <= r_way;
            r_hit_va  <= w_rdata.va;
            r_hit_vb  <= w_rdata.vb;
            r_old_wt  <= w_rdata.weight;
        end
        if (w_ctrl.cmp_en && !w_rdata.valid && !r_free) begin
            r_free_way <= r_way;
        end
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (w_ctrl.clr_wr && !w_stat.clr_last) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // result and write-back decision
    always_comb begin
        n_status = uehash_pkg::ST_MISSING;
        n_fw     = '0;
        w_we     = 1'b0;
        w_waddr  = w_base + uehash_pkg::ADDR_BITS'(r_free_way);
        w_wdata  = '{valid: 1'b1, va: r_va, vb: r_vb, weight: r_wt};
        if (w_ctrl.clr_wr) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (r_op == uehash_pkg::OP_LOOKUP) begin
            n_status = r_hit ? uehash_pkg::ST_FOUND : uehash_pkg::ST_MISSING;
            n_fw     = r_hit ? r_old_wt : '0;
        end else if (r_hit) begin
            n_status = uehash_pkg::ST_UPDATED;
            n_fw     = r_old_wt;
            w_we     = w_ctrl.wr_en;
            w_waddr  = w_base + uehash_pkg::ADDR_BITS'(r_hit_way);
            w_wdata  = '{valid: 1'b1, va: r_hit_va, vb: r_hit_vb, weight: r_wt};
        end else if (r_free) begin
            n_status = uehash_pkg::ST_INSERTED;
            w_we     = w_ctrl.wr_en;
        end else begin
            n_status = uehash_pkg::ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.wr_en) begin
            r_status <= n_status;
            r_fw     <= n_fw;
        end
    end

    // slot memory
    uehash_ram #(
        .DEPTH (uehash_pkg::SLOT_COUNT),
        .WIDTH (uehash_pkg::ENTRY_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_ctrl.rd_en),
        .i_raddr (w_base + uehash_pkg::ADDR_BITS'(r_way)),
        .o_rdata (w_rdata)
    );

    // ports
    assign i_in.ready         = w_ctrl.in_ready;
    assign o_out.valid        = w_ctrl.out_valid;
    assign o_out.status       = r_status;
    assign o_out.found_weight = r_fw;

    // a word never completes in the cycle after it is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !o_out.valid)
        else $error("result word one cycle after accept");

    // input side is closed while a result waits
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while result pending");

    // only hits carry a weight
    a_zero_weight_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (r_status == uehash_pkg::ST_INSERTED
                      || r_status == uehash_pkg::ST_MISSING
                      || r_status == uehash_pkg::ST_FULL)) |-> (o_out.found_weight == '0))
        else $error("nonzero weight without a match");

    // memory is written only by the clearing pass or the write-back step
    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (w_ctrl.clr_wr || w_ctrl.wr_en))
        else $error("slot write outside clear or write-back");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench for undirected_edge_hash_table
// depends on uehash_pkg, uehash_if and the block itself; carries its own edge table predictor

module tb_top;
    import uehash_pkg::*;

    localparam int VERTEX_MAX  = (1 << VERTEX_BITS) - 1;
    localparam int WEIGHT_MAX  = (1 << WEIGHT_BITS) - 1;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_WORDS = 305;

    // expected outcome of one edge operation
    typedef struct packed {
        t_status                status;
        logic [WEIGHT_BITS-1:0] weight;
    } t_result;

    typedef struct packed {
        logic [VERTEX_BITS-1:0] a;
        logic [VERTEX_BITS-1:0] b;
    } t_pair;

    logic i_clk = 1'b0;
    logic i_rst_n;

    uehash_in_if  in_if();
    uehash_out_if out_if();

    undirected_edge_hash_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // predicted table contents and expected result words
    t_entry  edge_slots [SLOT_COUNT];
    t_pair   stored_edges [$];
    t_result expected_q [$];

    int error_count   = 0;
    int words_sent    = 0;
    int stall_cycles  = 0;
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int hold_off_len  = 0;
    int status_seen [8];

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("ERROR at %0t ns: %s", $time, what);
    endtask

    // edge table predictor: applies one operation and returns the expected word
    function automatic t_result apply_edge_op(input logic op,
                                              input logic [VERTEX_BITS-1:0] a,
                                              input logic [VERTEX_BITS-1:0] b,
                                              input logic [WEIGHT_BITS-1:0] w);
        int      base;
        int      hit;
        int      free_way;
        t_result r;
        base     = (((int'(a) + int'(b)) * HASH_MULT) % HASH_MOD) * WAYS;
        hit      = -1;
        free_way = -1;
        // lowest way wins, scanning downward leaves the lowest
        for (int k = WAYS - 1; k >= 0; k--) begin
            if (edge_slots[base + k].valid) begin
                if ((edge_slots[base + k].va == a && edge_slots[base + k].vb == b) ||
                    (edge_slots[base + k].va == b && edge_slots[base + k].vb == a))
                    hit = k;
            end else begin
                free_way = k;
            end
        end
        r.weight = '0;
        if (op == OP_LOOKUP) begin
            if (hit >= 0) begin
                r.status = ST_FOUND;
                r.weight = edge_slots[base + hit].weight;
            end else begin
                r.status = ST_MISSING;
            end
        end else if (hit >= 0) begin
            r.status = ST_UPDATED;
            r.weight = edge_slots[base + hit].weight;
            edge_slots[base + hit].weight = w;
        end else if (free_way >= 0) begin
            r.status = ST_INSERTED;
            edge_slots[base + free_way] = '{valid: 1'b1, va: a, vb: b, weight: w};
            stored_edges.push_back('{a: a, b: b});
        end else begin
            r.status = ST_FULL;
        end
        return r;
    endfunction

    // offer one word, wait for it to be taken, then log its expected result
    task automatic send_word(input logic op,
                             input logic [VERTEX_BITS-1:0] a,
                             input logic [VERTEX_BITS-1:0] b,
                             input logic [WEIGHT_BITS-1:0] w);
        t_result r;
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.opcode      <= op;
        in_if.vertex_a    <= a;
        in_if.vertex_b    <= b;
        in_if.edge_weight <= w;
        do @(posedge i_clk);
        while (!(in_if.valid === 1'b1 && in_if.ready === 1'b1));
        r = apply_edge_op(op, a, b, w);
        expected_q.push_back(r);
        words_sent++;
    endtask

    // random word: mostly edges around a hot vertex range plus known edges
    task automatic random_word(input int hot_base);
        int                     pick;
        logic                   op;
        logic [VERTEX_BITS-1:0] a;
        logic [VERTEX_BITS-1:0] b;
        logic [WEIGHT_BITS-1:0] w;
        t_pair                  p;
        pick = $urandom_range(99);
        w    = WEIGHT_BITS'($urandom_range(WEIGHT_MAX));
        if ($urandom_range(19) == 0)
            w = WEIGHT_BITS'($urandom_range(1) ? WEIGHT_MAX : 0);
        a  = VERTEX_BITS'(hot_base + $urandom_range(47));
        b  = VERTEX_BITS'(hot_base + $urandom_range(47));
        op = OP_INSERT;
        if ($urandom_range(19) == 0)
            b = a;
        if (pick < 35) begin
            op = OP_INSERT;
        end else if (pick < 80 && stored_edges.size() != 0) begin
            // revisit a stored edge, either orientation
            p = stored_edges[$urandom_range(stored_edges.size() - 1)];
            a = p.a;
            b = p.b;
            if ($urandom_range(1)) begin
                a = p.b;
                b = p.a;
            end
            op = (pick < 55) ? OP_INSERT : OP_LOOKUP;
        end else if (pick < 90) begin
            op = OP_LOOKUP;
        end else begin
            op = 1'($urandom_range(1));
            a  = VERTEX_BITS'($urandom_range(VERTEX_MAX));
            b  = VERTEX_BITS'($urandom_range(VERTEX_MAX));
        end
        send_word(op, a, b, w);
    endtask

    // lookups and updates in both orientations, with a self loop
    task automatic test_orientation_and_update();
        send_word(OP_LOOKUP, 10'd0,  10'd40, 16'h5a5a);
        send_word(OP_INSERT, 10'd0,  10'd40, 16'h0000);
        send_word(OP_LOOKUP, 10'd40, 10'd0,  16'h0000);
        send_word(OP_INSERT, 10'd40, 10'd0,  16'hffff);
        send_word(OP_LOOKUP, 10'd0,  10'd40, 16'h0000);
        send_word(OP_INSERT, 10'd20, 10'd20, 16'h1234);
        send_word(OP_LOOKUP, 10'd20, 10'd20, 16'h0000);
    endtask

    // same vertex sum lands in the same bucket; an edge of another sum with the same hash then finds it full
    task automatic test_bucket_overflow();
        send_word(OP_INSERT, 10'd1,   10'd39, 16'h0101);
        send_word(OP_INSERT, 10'd3,   10'd37, 16'h0303);
        send_word(OP_INSERT, 10'd4,   10'd36, 16'h0404);
        send_word(OP_LOOKUP, 10'd4,   10'd36, 16'h0000);
        send_word(OP_INSERT, 10'd100, 10'd37, 16'h0505);
        send_word(OP_INSERT, 10'd39,  10'd1,  16'h0707);
        send_word(OP_LOOKUP, 10'd1,   10'd39, 16'h0000);
    endtask

    // vertex and weight extremes
    task automatic test_field_extremes();
        send_word(OP_INSERT, 10'd1023, 10'd1023, 16'hffff);
        send_word(OP_LOOKUP, 10'd1023, 10'd1023, 16'h0000);
        send_word(OP_INSERT, 10'd0,    10'd0,    16'h0000);
        send_word(OP_LOOKUP, 10'd0,    10'd0,    16'hffff);
        send_word(OP_INSERT, 10'd1023, 10'd0,    16'h8000);
        send_word(OP_LOOKUP, 10'd0,    10'd1023, 16'h0000);
        send_word(OP_INSERT, 10'd1023, 10'd0,    16'h0001);
        send_word(OP_LOOKUP, 10'd1023, 10'd0,    16'h0000);
    endtask

    // random traffic under one idling mix
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int hot_base);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (PHASE_WORDS) random_word(hot_base);
    endtask

    // long receiver hold-off while words keep coming, so the input stalls
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_off_len   = HOLD_CYCLES;
        repeat (16) random_word(100);
    endtask

    // result receiver: random stalls, or a long hold-off on request
    initial begin : result_sink
        int hold;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_len != 0) begin
                hold         = hold_off_len;
                hold_off_len = 0;
                out_if.ready <= 1'b0;
                repeat (hold - 1) @(posedge i_clk);
            end else begin
                out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result word with nothing expected, status %0d",
                                          out_if.status));
            end else begin
                want = expected_q.pop_front();
                status_seen[want.status]++;
                if (out_if.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              out_if.status, want.status));
                if (out_if.found_weight !== want.weight)
                    report_mismatch($sformatf("found_weight 0x%h, expected 0x%h",
                                              out_if.found_weight, want.weight));
            end
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // test sequence
    initial begin
        in_if.valid       <= 1'b0;
        in_if.opcode      <= OP_LOOKUP;
        in_if.vertex_a    <= '0;
        in_if.vertex_b    <= '0;
        in_if.edge_weight <= '0;
        i_rst_n           <= 1'b0;
        for (int k = 0; k < SLOT_COUNT; k++)
            edge_slots[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_orientation_and_update();
        test_bucket_overflow();
        test_field_extremes();
        test_random_traffic(0,  0,  0);
        test_random_traffic(56, 0,  200);
        test_random_traffic(0,  56, 400);
        test_random_traffic(28, 28, 600);
        test_backpressure();

        // drain
        in_if.valid    <= 1'b0;
        sink_stall_pct = 28;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("sent %0d words: %0d new, %0d updated, %0d found, %0d missed, %0d full",
                 words_sent, status_seen[ST_INSERTED], status_seen[ST_UPDATED],
                 status_seen[ST_FOUND], status_seen[ST_MISSING], status_seen[ST_FULL]);
        $display("idle mixes: none, sender, receiver, both; one %0d-cycle receiver hold-off",
                 HOLD_CYCLES);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
